FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TRLC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define TRLC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/core/trlc_pkg.sv
// types and constants of the text run lru tag store
`default_nettype none

package trlc_pkg;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam int SLOT_W  = 4;
    localparam int STAMP_W = 32;

    typedef struct packed {
        logic        func;
        logic [31:0] text_crc;
        logic [15:0] font_id;
        logic [7:0]  color_id;
        logic [15:0] text_length;
        logic        create_ok;
    } req_word_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic              present;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] font;
        logic [7:0]  color;
        logic [15:0] length;
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/trlc_ctrl.sv
// controller state machine of the text run lru tag store
`default_nettype none

module trlc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_func,
    output logic                       req_ready,
    input  wire trlc_pkg::dp_status_t  status,
    output trlc_pkg::ctrl_cmd_t        cmd
);
    import trlc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_func == FUNC_CLEAR) ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT, ST_CLEAR:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd.load      = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        cmd.clear     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            ST_CLEAR:
            begin
                cmd.clear = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/trlc_dpath.sv
// datapath of the text run lru tag store: tag and stamp memories, scan, response
`default_nettype none

module trlc_dpath #(
    parameter int ENTRIES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire trlc_pkg::req_word_t   req_word,
    input  wire trlc_pkg::ctrl_cmd_t   cmd,
    output trlc_pkg::dp_status_t       status,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output trlc_pkg::rsp_word_t        rsp_word
);
    import trlc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    tag_t               tag_mem   [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];

    req_word_t          req_reg;
    tag_t               req_tag;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   rd_addr_next;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    tag_t               tag_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;

    logic               hit_found_reg;
    logic               hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   hit_idx_next;
    logic               empty_found_reg;
    logic               empty_found_next;
    logic [IDX_W-1:0]   victim_reg;
    logic [IDX_W-1:0]   victim_next;
    logic [STAMP_W-1:0] oldest_reg;
    logic [STAMP_W-1:0] oldest_next;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [STAMP_W-1:0] counter_reg;
    logic [STAMP_W-1:0] counter_next;
    logic [STAMP_W-1:0] counter_inc;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_word_t          rsp_word_reg;
    rsp_word_t          rsp_word_next;

    logic               cmp_entry_valid;
    logic               cmp_match;
    logic               fill;
    logic               stamp_we;
    logic [IDX_W-1:0]   stamp_waddr;
    logic [WIDE_W-1:0]  slot_wide;

    assign req_tag.key    = req_reg.text_crc
                          ^ {8'd0, req_reg.font_id, 8'd0}
                          ^ {8'd0, req_reg.color_id, 16'd0};
    assign req_tag.font   = req_reg.font_id;
    assign req_tag.color  = req_reg.color_id;
    assign req_tag.length = req_reg.text_length;

    assign cmp_entry_valid = valid_reg[cmp_idx_reg];
    assign cmp_match       = cmp_entry_valid && (tag_rd_reg == req_tag);
    assign counter_inc     = counter_reg + STAMP_W'(1);
    assign fill            = cmd.commit && !hit_found_reg && req_reg.create_ok;
    assign stamp_we        = (cmd.commit && hit_found_reg) || fill;
    assign stamp_waddr     = hit_found_reg ? hit_idx_reg : victim_reg;

    assign status.scan_last = (rd_addr_reg == IDX_W'(ENTRIES - 1));
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // scan tracking: first hit, first empty slot, else lowest-index oldest stamp
    always_comb
    begin
        rd_addr_next     = cmd.scan_step ? rd_addr_reg + IDX_W'(1) : rd_addr_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        empty_found_next = empty_found_reg;
        victim_next      = victim_reg;
        oldest_next      = oldest_reg;
        if (cmd.load)
        begin
            rd_addr_next     = '0;
            hit_found_next   = 1'b0;
            hit_idx_next     = '0;
            empty_found_next = 1'b0;
            victim_next      = '0;
            oldest_next      = '1;
        end
        else if (cmp_valid_reg)
        begin
            if (cmp_match && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
            end
            if (!empty_found_reg)
            begin
                if (!cmp_entry_valid)
                begin
                    empty_found_next = 1'b1;
                    victim_next      = cmp_idx_reg;
                end
                else if (stamp_rd_reg < oldest_reg)
                begin
                    oldest_next = stamp_rd_reg;
                    victim_next = cmp_idx_reg;
                end
            end
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        counter_next  = counter_reg;
        rsp_word_next = rsp_word_reg;
        slot_wide     = WIDE_W'(hit_found_reg ? hit_idx_reg : victim_reg);
        if (cmd.clear)
        begin
            valid_next    = '0;
            counter_next  = '0;
            rsp_word_next = '0;
        end
        else if (cmd.commit)
        begin
            rsp_word_next.slot = slot_wide[SLOT_W-1:0];
            if (hit_found_reg)
            begin
                counter_next          = counter_inc;
                rsp_word_next.hit     = 1'b1;
                rsp_word_next.evicted = 1'b0;
                rsp_word_next.present = 1'b1;
            end
            else
            begin
                valid_next[victim_reg] = req_reg.create_ok;
                if (req_reg.create_ok)
                begin
                    counter_next = counter_inc;
                end
                rsp_word_next.hit     = 1'b0;
                rsp_word_next.evicted = valid_reg[victim_reg];
                rsp_word_next.present = req_reg.create_ok;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit || cmd.clear)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg     <= '0;
            cmp_valid_reg   <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            valid_reg       <= '0;
            counter_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_addr_reg     <= rd_addr_next;
            cmp_valid_reg   <= cmd.scan_step;
            hit_found_reg   <= hit_found_next;
            empty_found_reg <= empty_found_next;
            valid_reg       <= valid_next;
            counter_reg     <= counter_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_word;
        end
        hit_idx_reg  <= hit_idx_next;
        victim_reg   <= victim_next;
        oldest_reg   <= oldest_next;
        rsp_word_reg <= rsp_word_next;
    end

    // tag and stamp memories: one read and one write port each
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            tag_rd_reg   <= tag_mem[rd_addr_reg];
            stamp_rd_reg <= stamp_mem[rd_addr_reg];
            cmp_idx_reg  <= rd_addr_reg;
        end
        if (fill)
        begin
            tag_mem[victim_reg] <= req_tag;
        end
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= counter_inc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/text_run_lru_cache_core.sv
// top level of the text run lru tag store
`default_nettype none

// Fully associative tag store for cached text runs with least-recently-used
// replacement. A lookup word is accepted in the idle state; the scan state then
// walks the entries one a cycle through the single read port of the tag and
// stamp memories, the drain state compares the last entry, and the commit state
// writes the stamp or the refilled tag and loads the response register. No new
// word is accepted before that commit. An accepted clear goes to the clear
// state, which clears the valid bits and loads the response register.
// The commit and clear steps wait while the response register still holds an
// untaken word. Valid bits are flip-flops cleared by reset; the memories need
// no clearing pass.
module text_run_lru_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire trlc_pkg::req_word_t req_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output trlc_pkg::rsp_word_t      rsp_word
);
    import trlc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    trlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req_word.func),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    trlc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

`include "assert_macros.svh"

    `TRLC_ASSERT(a_busy_after_accept, clk, rst_n,
        (req_valid && req_ready) |=> !req_ready, "accepted word did not make the block busy")
    `TRLC_ASSERT(a_rsp_from_cmd, clk, rst_n,
        $rose(rsp_valid) |-> $past(cmd.commit || cmd.clear), "response without commit or clear")
    `TRLC_ASSERT(a_no_overwrite, clk, rst_n,
        (cmd.commit || cmd.clear) |-> (!rsp_valid || rsp_ready), "response register overwritten")
    `TRLC_ASSERT_NEVER(a_single_cmd, clk, rst_n,
        cmd.commit && cmd.clear, "commit and clear issued together")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// testbench of the text run lru tag store: predicted responses checked word by word
module tb_top;

    import trlc_pkg::*;

    localparam int SLOTS = 16;
    localparam int RANDOM_RUNS = 1850;
    localparam int POOL_MAX = 22;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req_word = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp_word;

    // mirror of the tag store
    logic        tag_live [SLOTS];
    logic [31:0] tag_key [SLOTS];
    logic [15:0] tag_font [SLOTS];
    logic [7:0]  tag_color [SLOTS];
    logic [15:0] tag_len [SLOTS];
    logic [31:0] tag_stamp [SLOTS];
    logic [31:0] use_count;

    req_word_t run_backlog[$];
    rsp_word_t lru_answers[$];
    req_word_t recent_runs[$];

    int  words_queued = 0;
    int  words_sent = 0;
    int  words_taken = 0;
    int  mismatches = 0;
    int  n_hits = 0;
    int  n_fills = 0;
    int  n_failed = 0;
    int  n_evicts = 0;
    int  n_clears = 0;
    int  send_pause = 0;
    int  take_pause = 0;
    bit  send_calm = 1'b0;
    bit  take_calm = 1'b0;

    text_run_lru_cache_core #(
        .ENTRIES(SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word(rsp_word)
    );

    function automatic rsp_word_t lru_lookup(req_word_t w);
        rsp_word_t   r;
        logic [31:0] key;
        logic [31:0] oldest;
        int          victim;
        r = '0;
        if (w.func == FUNC_CLEAR)
        begin
            foreach (tag_live[i])
                tag_live[i] = 1'b0;
            use_count = '0;
            n_clears++;
            return r;
        end
        key = w.text_crc ^ {8'h00, w.font_id, 8'h00} ^ {8'h00, w.color_id, 16'h0000};
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tag_live[i] && tag_key[i] == key && tag_font[i] == w.font_id &&
                tag_color[i] == w.color_id && tag_len[i] == w.text_length)
            begin
                use_count = use_count + 1;
                tag_stamp[i] = use_count;
                r.hit = 1'b1;
                r.slot = SLOT_W'(i);
                r.present = 1'b1;
                n_hits++;
                return r;
            end
        end
        victim = -1;
        for (int i = 0; i < SLOTS; i++)
            if (victim < 0 && !tag_live[i])
                victim = i;
        if (victim < 0)
        begin
            victim = 0;
            oldest = '1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tag_stamp[i] < oldest)
                begin
                    oldest = tag_stamp[i];
                    victim = i;
                end
            end
        end
        r.slot = SLOT_W'(victim);
        r.evicted = tag_live[victim];
        if (tag_live[victim])
            n_evicts++;
        tag_live[victim] = 1'b0;
        if (w.create_ok)
        begin
            use_count = use_count + 1;
            tag_live[victim] = 1'b1;
            tag_key[victim] = key;
            tag_font[victim] = w.font_id;
            tag_color[victim] = w.color_id;
            tag_len[victim] = w.text_length;
            tag_stamp[victim] = use_count;
            r.present = 1'b1;
            n_fills++;
        end
        else
            n_failed++;
        return r;
    endfunction

    function automatic req_word_t run_word(logic [31:0] crc, logic [15:0] font,
                                           logic [7:0] color, logic [15:0] len, logic create);
        req_word_t w;
        w.func = FUNC_LOOKUP;
        w.text_crc = crc;
        w.font_id = font;
        w.color_id = color;
        w.text_length = len;
        w.create_ok = create;
        return w;
    endfunction

    function automatic req_word_t fresh_run(logic create);
        return run_word($urandom, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), create);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // request driver, predicts each word as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word <= '0;
            send_pause <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                lru_answers.push_back(lru_lookup(req_word));
                words_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (send_pause != 0)
                begin
                    send_pause <= send_pause - 1;
                    req_valid <= 1'b0;
                end
                else if (run_backlog.size() != 0)
                begin
                    req_word <= run_backlog.pop_front();
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_pause <= send_calm ? 0 : int'($urandom_range(0, 17));
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor with random back pressure
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        int        s;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            take_pause <= 0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            if (lru_answers.size() == 0)
            begin
                if (mismatches < 10)
                    $display("word %0d unexpected: hit=%0b slot=%0d evicted=%0b present=%0b",
                             words_taken, rsp_word.hit, rsp_word.slot, rsp_word.evicted,
                             rsp_word.present);
                mismatches++;
            end
            else
            begin
                want = lru_answers.pop_front();
                if (rsp_word.hit !== want.hit || rsp_word.slot !== want.slot ||
                    rsp_word.evicted !== want.evicted || rsp_word.present !== want.present)
                begin
                    if (mismatches < 10)
                        $display("word %0d: hit,slot,ev,pres want %0b,%0d,%0b,%0b got %0b,%0d,%0b,%0b",
                                 words_taken, want.hit, want.slot, want.evicted, want.present,
                                 rsp_word.hit, rsp_word.slot, rsp_word.evicted,
                                 rsp_word.present);
                    mismatches++;
                end
            end
            words_taken++;
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
            s = take_calm ? 0 : int'($urandom_range(0, 17));
            rsp_ready <= (s == 0);
            take_pause <= (s == 0) ? 0 : s - 1;
        end
        else if (take_pause != 0)
        begin
            take_pause <= take_pause - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    initial
    begin
        req_word_t w;
        req_word_t base;
        logic [15:0] f2;
        logic [7:0]  c2;
        int pick;
        int k;

        foreach (tag_live[i])
        begin
            tag_live[i] = 1'b0;
            tag_key[i] = '0;
            tag_font[i] = '0;
            tag_color[i] = '0;
            tag_len[i] = '0;
            tag_stamp[i] = '0;
        end
        use_count = '0;

        // directed part
        w = run_word('1, '1, '1, '1, 1'b1);
        w.func = FUNC_CLEAR;
        run_backlog.push_back(w);
        run_backlog.push_back(run_word('0, '0, '0, '0, 1'b1));
        run_backlog.push_back(run_word('0, '0, '0, '0, 1'b0));
        run_backlog.push_back(run_word('1, '1, '1, '1, 1'b1));
        // same key, other font
        run_backlog.push_back(run_word(32'hFFFF_FFFF ^ {8'h00, 16'hFFFF ^ 16'h1234, 8'h00},
                                       16'h1234, '1, '1, 1'b1));
        // same key, other color, creation refused
        run_backlog.push_back(run_word(32'hFFFF_FFFF ^ {8'h00, 8'hFF ^ 8'h5A, 16'h0000},
                                       '1, 8'h5A, '1, 1'b0));
        run_backlog.push_back(run_word('0, '0, '0, 16'h0001, 1'b1));
        for (k = 0; k < 12; k++)
            run_backlog.push_back(fresh_run(1'b1));
        run_backlog.push_back(run_word('0, '0, '0, '0, 1'b1));
        run_backlog.push_back(fresh_run(1'b1));
        run_backlog.push_back(fresh_run(1'b0));
        run_backlog.push_back(fresh_run(1'b1));
        run_backlog.push_back(run_word('0, '0, '0, 16'h0001, 1'b1));
        w = run_word('0, '0, '0, '0, 1'b0);
        w.func = FUNC_CLEAR;
        run_backlog.push_back(w);

        // random part: mostly reuse of recent runs, some near misses, fresh runs and clears
        for (k = 0; k < RANDOM_RUNS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                w = fresh_run(1'($urandom_range(0, 1)));
                w.func = FUNC_CLEAR;
            end
            else if (pick < 58 && recent_runs.size() != 0)
                w = recent_runs[$urandom_range(0, recent_runs.size() - 1)];
            else if (pick < 74 && recent_runs.size() != 0)
            begin
                base = recent_runs[$urandom_range(0, recent_runs.size() - 1)];
                w = base;
                case ($urandom_range(0, 3))
                    0: w.text_length = base.text_length ^ (16'h1 << $urandom_range(0, 15));
                    1:
                    begin
                        f2 = 16'($urandom_range(0, 65535));
                        w.text_crc = base.text_crc ^ {8'h00, base.font_id ^ f2, 8'h00};
                        w.font_id = f2;
                    end
                    2:
                    begin
                        c2 = 8'($urandom_range(0, 255));
                        w.text_crc = base.text_crc ^ {8'h00, base.color_id ^ c2, 16'h0000};
                        w.color_id = c2;
                    end
                    default: w.text_crc = base.text_crc ^ (32'h1 << $urandom_range(0, 31));
                endcase
            end
            else
            begin
                w = fresh_run(1'b1);
                recent_runs.push_back(w);
                if (recent_runs.size() > POOL_MAX)
                    recent_runs.delete($urandom_range(0, recent_runs.size() - 1));
            end
            if (w.func == FUNC_LOOKUP)
                w.create_ok = ($urandom_range(0, 4) != 0);
            run_backlog.push_back(w);
        end
        words_queued = run_backlog.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (words_sent != words_queued || lru_answers.size() != 0);
        repeat (60) @(negedge clk);

        $display("%0d words checked: %0d hits, %0d fills, %0d refused creations, %0d evictions",
                 words_taken, n_hits, n_fills, n_failed, n_evicts);
        $display("%0d clears, %0d mismatches", n_clears, mismatches);
        if (mismatches == 0 && lru_answers.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/trlc_pkg.sv
rtl/core/trlc_ctrl.sv
rtl/core/trlc_dpath.sv
rtl/core/text_run_lru_cache_core.sv
bench/tb_top.sv
